// ===== hdl/fmrb_pkg.sv =====
// Package for the Fock matrix row builder: sizes, op codes, register indices, sequencer states.
// No dependencies.
package fmrb_pkg;

    localparam int MaxOrbitals  = 16;
    localparam int MaxParticles = 8;
    localparam int HalfOrb      = MaxOrbitals / 2;
    localparam int FracBits     = 20;

    typedef enum logic [1:0] {
        OP_ENERGY  = 2'd0,
        OP_COULOMB = 2'd1,
        OP_COEF    = 2'd2,
        OP_COMPUTE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CFG_NUM_ORBITALS  = 2'd0,
        CFG_NUM_PARTICLES = 2'd1,
        CFG_SPARE2        = 2'd2,
        CFG_SPARE3        = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COL_INIT,
        ST_ADDR_B,
        ST_ADDR_D,
        ST_MUL_PAIR,
        ST_MUL_TERM,
        ST_ACCUM,
        ST_FIN
    } state_t;

endpackage

// ===== hdl/fock_matrix_row_build.sv =====
// Fock matrix row builder: stores, sequencer and one shared 33x33 multiplier.
// Depends on fmrb_pkg.
//
// channel   | dir | handshake              | payload
// s_axis    | in  | s_axis_tvalid/tready   | tuser = op, tdata = indices, load value
// m_axis    | out | m_axis_tvalid/tready   | tdata = row, column, element; tlast = last
// cfg       | in  | cfg_valid/cfg_ready    | cfg_index, cfg_data (always ready)
//
// Loads are taken in ST_IDLE and leave the block idle. A compute item runs a
// five-step read/multiply/add per term, set by the single shared multiplier used
// twice per term and the one-read-port coefficient and Coulomb memories.
// Reset clears control state only; stores hold garbage until written.
// The block stalls at a column end while the previous result waits for tready.
module fock_matrix_row_build (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [3:0] index_first, [7:4] index_second, [11:8] index_third,
    // [15:12] index_fourth, [47:16] load_value
    input  logic [47:0] s_axis_tdata,
    // [1:0] op
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [3:0] row_index, [7:4] column_index, [39:8] element_value
    output logic [39:0] m_axis_tdata,
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [4:0]  cfg_data
);

    fmrb_pkg::state_t state_reg, state_next;

    logic [4:0] num_orb_reg;
    logic [3:0] num_part_reg;

    // per-row working registers
    logic [3:0] row_reg;
    logic [4:0] m_reg;
    logic [3:0] p_reg;
    logic [3:0] g_reg, b_reg, d_reg;
    logic [2:0] i_reg;

    // stores
    logic signed [31:0] energy_mem [fmrb_pkg::HalfOrb];
    logic signed [31:0] coef_mem   [fmrb_pkg::MaxParticles * fmrb_pkg::MaxOrbitals];
    logic signed [31:0] coul_mem   [4096];
    logic signed [31:0] coef_rdata_reg, coul_rdata_reg;
    logic [6:0]  coef_raddr;
    logic [11:0] coul_raddr;

    logic signed [31:0] cb_reg, vdir_reg;
    logic signed [32:0] w_reg;
    logic signed [65:0] prod_reg;
    logic signed [63:0] acc_reg;
    logic signed [32:0] mul_a, mul_b;

    logic        out_valid_reg;
    logic [39:0] out_data_reg;
    logic        out_last_reg;

    // input fields
    fmrb_pkg::op_t op;
    logic [3:0] in_a, in_b, in_g, in_d;
    logic signed [31:0] in_val;
    assign op     = fmrb_pkg::op_t'(s_axis_tuser);
    assign in_a   = s_axis_tdata[3:0];
    assign in_b   = s_axis_tdata[7:4];
    assign in_g   = s_axis_tdata[11:8];
    assign in_d   = s_axis_tdata[15:12];
    assign in_val = s_axis_tdata[47:16];

    logic in_xfer;
    assign in_xfer = s_axis_tvalid && s_axis_tready;

    // effective sizes from the registers
    logic [4:0] m_eff;
    logic [3:0] p_eff;
    always_comb
    begin
        m_eff = num_orb_reg & 5'h1E;
        if (m_eff < 5'd2)
            m_eff = 5'd2;
        if (m_eff > 5'd16)
            m_eff = 5'd16;
        p_eff = num_part_reg;
        if (p_eff == 4'd0)
            p_eff = 4'd1;
        if (p_eff > 4'd8)
            p_eff = 4'd8;
    end

    logic start_row;
    assign start_row = in_xfer && (op == fmrb_pkg::OP_COMPUTE) && ({1'b0, in_a} < m_eff);

    logic d_last, b_last, i_last, g_last;
    assign d_last = ({1'b0, d_reg} == m_reg - 5'd1);
    assign b_last = ({1'b0, b_reg} == m_reg - 5'd1);
    assign g_last = ({1'b0, g_reg} == m_reg - 5'd1);
    assign i_last = ({1'b0, i_reg} == p_reg - 4'd1);

    logic out_free;
    assign out_free = !out_valid_reg || m_axis_tready;

    // spin selection rules
    logic dir_ok, ex_ok;
    assign dir_ok = (row_reg[0] == g_reg[0]) && (b_reg[0] == d_reg[0]);
    assign ex_ok  = (row_reg[0] == d_reg[0]) && (b_reg[0] == g_reg[0]);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fmrb_pkg::ST_IDLE:     if (start_row) state_next = fmrb_pkg::ST_COL_INIT;
            fmrb_pkg::ST_COL_INIT: state_next = fmrb_pkg::ST_ADDR_B;
            fmrb_pkg::ST_ADDR_B:   state_next = fmrb_pkg::ST_ADDR_D;
            fmrb_pkg::ST_ADDR_D:   state_next = fmrb_pkg::ST_MUL_PAIR;
            fmrb_pkg::ST_MUL_PAIR: state_next = fmrb_pkg::ST_MUL_TERM;
            fmrb_pkg::ST_MUL_TERM: state_next = fmrb_pkg::ST_ACCUM;
            fmrb_pkg::ST_ACCUM:
                state_next = (d_last && b_last && i_last) ? fmrb_pkg::ST_FIN
                                                          : fmrb_pkg::ST_ADDR_B;
            fmrb_pkg::ST_FIN:
                if (out_free)
                    state_next = g_last ? fmrb_pkg::ST_IDLE : fmrb_pkg::ST_COL_INIT;
            default:               state_next = fmrb_pkg::ST_IDLE;
        endcase
    end

    // pair product back to Q12.20, saturated to 32 bits
    logic signed [32:0] pair_sat;
    always_comb
    begin
        if (prod_reg[65:51] == {15{prod_reg[51]}})
            pair_sat = {prod_reg[51], prod_reg[51:20]};
        else if (prod_reg[65])
            pair_sat = {1'b1, 32'h8000_0000};
        else
            pair_sat = {1'b0, 32'h7FFF_FFFF};
    end

    // control outputs: handshake, memory addresses, multiplier operands
    always_comb
    begin
        s_axis_tready = (state_reg == fmrb_pkg::ST_IDLE);
        coef_raddr    = {i_reg, b_reg};
        coul_raddr    = {row_reg[3:1], b_reg[3:1], g_reg[3:1], d_reg[3:1]};
        mul_a         = {coef_rdata_reg[31], coef_rdata_reg};
        mul_b         = {cb_reg[31], cb_reg};
        unique case (state_reg)
            fmrb_pkg::ST_ADDR_D:
            begin
                coef_raddr = {i_reg, d_reg};
                coul_raddr = {row_reg[3:1], b_reg[3:1], d_reg[3:1], g_reg[3:1]};
            end
            fmrb_pkg::ST_MUL_TERM:
            begin
                mul_a = pair_sat;
                mul_b = w_reg;
            end
            default:
            begin
            end
        endcase
    end

    // accumulate with saturation at +-2^62
    localparam logic signed [63:0] AccLimit = 64'sh4000_0000_0000_0000;
    logic signed [63:0] acc_sum;
    logic signed [63:0] acc_sat;
    assign acc_sum = acc_reg + {{18{prod_reg[65]}}, prod_reg[65:20]};
    always_comb
    begin
        if (acc_sum > AccLimit)
            acc_sat = AccLimit;
        else if (acc_sum < -AccLimit)
            acc_sat = -AccLimit;
        else
            acc_sat = acc_sum;
    end

    logic signed [31:0] elem_sat;
    always_comb
    begin
        if (acc_reg[63:31] == {33{acc_reg[31]}})
            elem_sat = acc_reg[31:0];
        else if (acc_reg[63])
            elem_sat = 32'sh8000_0000;
        else
            elem_sat = 32'sh7FFF_FFFF;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fmrb_pkg::ST_IDLE;
            num_orb_reg   <= 5'd16;
            num_part_reg  <= 4'd2;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (fmrb_pkg::cfg_index_t'(cfg_index))
                    fmrb_pkg::CFG_NUM_ORBITALS:  num_orb_reg  <= cfg_data;
                    fmrb_pkg::CFG_NUM_PARTICLES: num_part_reg <= cfg_data[3:0];
                    default:
                    begin
                    end
                endcase
            end
            if (state_reg == fmrb_pkg::ST_FIN && out_free)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    assign cfg_ready = 1'b1;

    // memories: one write each; coefficient and Coulomb stores have one registered read each
    always_ff @(posedge clk)
    begin
        if (in_xfer && op == fmrb_pkg::OP_COEF && !in_a[3])
            coef_mem[{in_a[2:0], in_b}] <= in_val;
        coef_rdata_reg <= coef_mem[coef_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer && op == fmrb_pkg::OP_COULOMB && !in_a[3] && !in_b[3] && !in_g[3]
            && !in_d[3])
            coul_mem[{in_a[2:0], in_b[2:0], in_g[2:0], in_d[2:0]}] <= in_val;
        coul_rdata_reg <= coul_mem[coul_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer && op == fmrb_pkg::OP_ENERGY && !in_a[3])
            energy_mem[in_a[2:0]] <= in_val;
    end

    // datapath and loop counters
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            fmrb_pkg::ST_IDLE:
            begin
                row_reg <= in_a;
                m_reg   <= m_eff;
                p_reg   <= p_eff;
                g_reg   <= 4'd0;
                i_reg   <= 3'd0;
                b_reg   <= 4'd0;
                d_reg   <= 4'd0;
            end
            fmrb_pkg::ST_COL_INIT:
                acc_reg <= (g_reg == row_reg) ? 64'(energy_mem[row_reg[3:1]]) : 64'sd0;
            fmrb_pkg::ST_ADDR_D:
            begin
                cb_reg   <= coef_rdata_reg;
                vdir_reg <= coul_rdata_reg;
            end
            fmrb_pkg::ST_MUL_PAIR:
            begin
                prod_reg <= mul_a * mul_b;
                w_reg    <= (dir_ok ? 33'(vdir_reg) : 33'sd0)
                          - (ex_ok ? 33'(coul_rdata_reg) : 33'sd0);
            end
            fmrb_pkg::ST_MUL_TERM:
                prod_reg <= mul_a * mul_b;
            fmrb_pkg::ST_ACCUM:
            begin
                acc_reg <= acc_sat;
                d_reg   <= d_last ? 4'd0 : d_reg + 4'd1;
                if (d_last)
                begin
                    b_reg <= b_last ? 4'd0 : b_reg + 4'd1;
                    if (b_last)
                        i_reg <= i_last ? 3'd0 : i_reg + 3'd1;
                end
            end
            fmrb_pkg::ST_FIN:
                if (out_free)
                begin
                    out_data_reg <= {elem_sat, g_reg, row_reg};
                    out_last_reg <= g_last;
                    g_reg        <= g_reg + 4'd1;
                end
            default:
            begin
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

// ===== hdl/fmrb_checker.sv =====
// Port-level checks for the Fock matrix row builder, bound to the top level.
// Depends on fmrb_pkg and the fock_matrix_row_build ports.
module fmrb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // a load leaves the block ready again in the next cycle
    a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser != fmrb_pkg::OP_COMPUTE
        |=> s_axis_tready)
        else $error("block busy after a load");

    // a pending mid-row result means the row is still in progress
    a_busy_mid_row: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input taken in the middle of a row");

endmodule

bind fock_matrix_row_build fmrb_checker u_fmrb_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/sv/testbench.sv =====
// Testbench for fock_matrix_row_build: drives load/compute items over the input stream,
// predicts every Fock element in-line and checks each output transfer in order.
// Depends on fmrb_pkg and the fock_matrix_row_build RTL.
module testbench;

    typedef struct packed {
        logic [3:0]  row;
        logic [3:0]  col;
        logic [31:0] value;
        logic        last;
    } fock_elem_t;

    // computes stay within this many spin-orbitals, all of whose entries get loaded
    localparam int FillOrb = 4;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [4:0]  cfg_data;

    // mirror of the block's stores and registers
    int          energy_mem [fmrb_pkg::HalfOrb];
    int          coulomb_mem [fmrb_pkg::HalfOrb*fmrb_pkg::HalfOrb*fmrb_pkg::HalfOrb*
                              fmrb_pkg::HalfOrb];
    int          coef_mem [fmrb_pkg::MaxParticles*fmrb_pkg::MaxOrbitals];
    logic [4:0]  orbitals_reg;
    logic [3:0]  particles_reg;

    fock_elem_t  pending_elems [$];
    int          error_count;
    bit          quiet;        // no idling on either side
    int          sink_hold;    // long receiver hold-off, in cycles

    fock_matrix_row_build dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // ---------------------------------------------------------------
    // Prediction
    // ---------------------------------------------------------------
    function automatic longint clamp_signed(longint x, int bits);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (x > hi)
            return hi;
        if (x < lo)
            return lo;
        return x;
    endfunction

    function automatic int coulomb_addr(int a, int b, int g, int d);
        return ((a * fmrb_pkg::HalfOrb + b) * fmrb_pkg::HalfOrb + g) * fmrb_pkg::HalfOrb + d;
    endfunction

    // antisymmetrized two-electron element over spin-orbitals
    function automatic longint antisym_elem(int a, int b, int g, int d);
        longint v;
        v = 0;
        if (a[0] == g[0] && b[0] == d[0])
            v += longint'(coulomb_mem[coulomb_addr(a/2, b/2, g/2, d/2)]);
        if (a[0] == d[0] && b[0] == g[0])
            v -= longint'(coulomb_mem[coulomb_addr(a/2, b/2, d/2, g/2)]);
        return v;
    endfunction

    function automatic int active_orbitals();
        int m;
        m = int'(orbitals_reg & 5'h1E);
        if (m < 2)
            m = 2;
        if (m > fmrb_pkg::MaxOrbitals)
            m = fmrb_pkg::MaxOrbitals;
        return m;
    endfunction

    function automatic int active_particles();
        int p;
        p = int'(particles_reg);
        if (p < 1)
            p = 1;
        if (p > fmrb_pkg::MaxParticles)
            p = fmrb_pkg::MaxParticles;
        return p;
    endfunction

    task automatic predict_fock_row(input int row);
        int         m;
        int         p;
        longint     acc;
        longint     cb;
        longint     cd;
        longint     pair;
        longint     w;
        longint     hi;
        longint     lo;
        longint     term;
        fock_elem_t e;
        m = active_orbitals();
        p = active_particles();
        if (row >= m)
            return;    // row out of range: nothing comes out
        for (int g = 0; g < m; g++)
        begin
            acc = (g == row) ? longint'(energy_mem[row/2]) : 0;
            for (int i = 0; i < p; i++)
                for (int b = 0; b < m; b++)
                begin
                    cb = longint'(coef_mem[i*fmrb_pkg::MaxOrbitals + b]);
                    for (int d = 0; d < m; d++)
                    begin
                        cd   = longint'(coef_mem[i*fmrb_pkg::MaxOrbitals + d]);
                        pair = clamp_signed((cb * cd) >>> fmrb_pkg::FracBits, 32);
                        w    = antisym_elem(row, b, g, d);
                        if (w != 0)
                        begin
                            hi   = pair >>> fmrb_pkg::FracBits;
                            lo   = pair - (hi <<< fmrb_pkg::FracBits);
                            term = hi * w + ((lo * w) >>> fmrb_pkg::FracBits);
                            acc  = clamp_signed(acc + term, 64);
                            if (acc > (64'sd1 <<< 62))
                                acc = 64'sd1 <<< 62;
                            if (acc < -(64'sd1 <<< 62))
                                acc = -(64'sd1 <<< 62);
                        end
                    end
                end
            e.row   = row[3:0];
            e.col   = g[3:0];
            e.value = 32'(clamp_signed(acc, 32));
            e.last  = (g == m - 1);
            pending_elems.push_back(e);
        end
    endtask

    task automatic apply_item(input fmrb_pkg::op_t op, input logic [3:0] i1,
                              input logic [3:0] i2, input logic [3:0] i3,
                              input logic [3:0] i4, input logic [31:0] val);
        case (op)
            fmrb_pkg::OP_ENERGY:
                if (i1 < fmrb_pkg::HalfOrb)
                    energy_mem[i1] = val;
            fmrb_pkg::OP_COULOMB:
                if (i1 < fmrb_pkg::HalfOrb && i2 < fmrb_pkg::HalfOrb
                    && i3 < fmrb_pkg::HalfOrb && i4 < fmrb_pkg::HalfOrb)
                    coulomb_mem[coulomb_addr(i1, i2, i3, i4)] = val;
            fmrb_pkg::OP_COEF:
                if (i1 < fmrb_pkg::MaxParticles && i2 < fmrb_pkg::MaxOrbitals)
                    coef_mem[i1*fmrb_pkg::MaxOrbitals + i2] = val;
            default:
                predict_fock_row(int'(i1));
        endcase
    endtask

    // ---------------------------------------------------------------
    // Driving
    // ---------------------------------------------------------------
    // one item, held until its transfer; tvalid stays high for a follow-on item
    task automatic send_item(input fmrb_pkg::op_t op, input logic [3:0] i1,
                             input logic [3:0] i2, input logic [3:0] i3,
                             input logic [3:0] i4, input logic [31:0] val);
        int gap;
        @(negedge clk);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 16);
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tdata  = {val, i4, i3, i2, i1};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        apply_item(op, i1, i2, i3, i4, val);
    endtask

    task automatic drop_valid();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    // registers change only with nothing in flight
    task automatic write_reg(input fmrb_pkg::cfg_index_t idx, input logic [4:0] data);
        drop_valid();
        while (pending_elems.size() != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == fmrb_pkg::CFG_NUM_ORBITALS)
            orbitals_reg = data;
        else if (idx == fmrb_pkg::CFG_NUM_PARTICLES)
            particles_reg = data[3:0];
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // mostly small Q12.20 magnitudes, sometimes full-range words
    function automatic logic [31:0] rand_value();
        if ($urandom_range(0, 3) == 0)
            return $urandom();
        return 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
    endfunction

    // receiver: random stall bursts, or a long hold-off on request
    initial
    begin
        int burst;
        burst = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (sink_hold > 0)
            begin
                m_axis_tready = 1'b0;
                sink_hold--;
            end
            else if (burst > 0)
            begin
                m_axis_tready = 1'b0;
                burst--;
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                m_axis_tready = 1'b0;
                burst = $urandom_range(0, 15);
            end
            else
                m_axis_tready = 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Checking
    // ---------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        fock_elem_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_elems.size() == 0)
                report_mismatch("unexpected element", m_axis_tdata[39:8], 32'd0);
            else
            begin
                want = pending_elems.pop_front();
                if (m_axis_tdata[3:0] != want.row)
                    report_mismatch("row_index", 32'(m_axis_tdata[3:0]), 32'(want.row));
                if (m_axis_tdata[7:4] != want.col)
                    report_mismatch("column_index", 32'(m_axis_tdata[7:4]), 32'(want.col));
                if (m_axis_tdata[39:8] != want.value)
                    report_mismatch("element_value", m_axis_tdata[39:8], want.value);
                if (m_axis_tlast != want.last)
                    report_mismatch("last_of_row", 32'(m_axis_tlast), 32'(want.last));
            end
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // every entry a compute within FillOrb spin-orbitals can reach gets defined
    task automatic test_fill_stores();
        quiet = 1'b1;
        for (int a = 0; a < FillOrb/2; a++)
            send_item(fmrb_pkg::OP_ENERGY, a[3:0], 4'd0, 4'd0, 4'd0, rand_value());
        for (int n = 0; n < 16; n++)
            send_item(fmrb_pkg::OP_COULOMB, 4'((n >> 3) & 1), 4'((n >> 2) & 1),
                      4'((n >> 1) & 1), 4'(n & 1), rand_value());
        for (int i = 0; i < fmrb_pkg::MaxParticles; i++)
            for (int b = 0; b < FillOrb; b++)
                send_item(fmrb_pkg::OP_COEF, i[3:0], b[3:0], 4'd0, 4'd0, rand_value());
        quiet = 1'b0;
    endtask

    // field extremes, ignored loads, every op and register limits
    task automatic test_extremes();
        write_reg(fmrb_pkg::CFG_NUM_ORBITALS, 5'd0);     // clamps to two orbitals
        write_reg(fmrb_pkg::CFG_NUM_PARTICLES, 5'd0);    // clamps to one particle
        write_reg(fmrb_pkg::CFG_SPARE2, 5'h1F);          // no such register
        write_reg(fmrb_pkg::CFG_SPARE3, 5'h00);
        send_item(fmrb_pkg::OP_ENERGY, 4'd0, 4'hF, 4'hF, 4'hF, 32'h7FFF_FFFF);
        send_item(fmrb_pkg::OP_ENERGY, 4'hF, 4'd0, 4'd0, 4'd0, 32'h8000_0000);   // ignored
        send_item(fmrb_pkg::OP_COULOMB, 4'd0, 4'd0, 4'd0, 4'd0, 32'h8000_0000);
        send_item(fmrb_pkg::OP_COULOMB, 4'hF, 4'hF, 4'hF, 4'hF, 32'hFFFF_FFFF);  // ignored
        send_item(fmrb_pkg::OP_COULOMB, 4'd0, 4'd0, 4'd8, 4'd0, 32'h1234_5678);  // ignored
        send_item(fmrb_pkg::OP_COEF, 4'd0, 4'd0, 4'd0, 4'd0, 32'h7FFF_FFFF);
        send_item(fmrb_pkg::OP_COEF, 4'd0, 4'hF, 4'd0, 4'd0, 32'h8000_0000);
        send_item(fmrb_pkg::OP_COEF, 4'hF, 4'd0, 4'd0, 4'd0, 32'h0000_0001);     // ignored
        send_item(fmrb_pkg::OP_COMPUTE, 4'd0, 4'd0, 4'd0, 4'd0, 32'd0);
        send_item(fmrb_pkg::OP_COMPUTE, 4'd1, 4'hF, 4'hF, 4'hF, 32'hFFFF_FFFF);
        send_item(fmrb_pkg::OP_COMPUTE, 4'hF, 4'd0, 4'd0, 4'd0, 32'd0);  // row out of range
        write_reg(fmrb_pkg::CFG_NUM_ORBITALS, 5'd5);     // odd: bit 0 dropped
        write_reg(fmrb_pkg::CFG_NUM_PARTICLES, 5'd1);
        send_item(fmrb_pkg::OP_COMPUTE, 4'hF, 4'd0, 4'd0, 4'd0, 32'd0);
        send_item(fmrb_pkg::OP_COMPUTE, 4'd0, 4'd0, 4'd0, 4'd0, 32'd0);
        write_reg(fmrb_pkg::CFG_NUM_ORBITALS, 5'd2);
        write_reg(fmrb_pkg::CFG_NUM_PARTICLES, 5'hF);    // caps at eight
        send_item(fmrb_pkg::OP_COMPUTE, 4'd1, 4'd0, 4'd0, 4'd0, 32'd0);
    endtask

    // hold the sink off while short rows keep arriving, so the input backs up
    task automatic test_backpressure();
        write_reg(fmrb_pkg::CFG_NUM_ORBITALS, 5'd2);
        write_reg(fmrb_pkg::CFG_NUM_PARTICLES, 5'd1);
        @(negedge clk);
        sink_hold = 3000;
        for (int n = 0; n < 8; n++)
            send_item(fmrb_pkg::OP_COMPUTE, 4'(n & 1), 4'd0, 4'd0, 4'd0, 32'd0);
    endtask

    // random loads into the live range, some noise, computes of random rows;
    // m stays within FillOrb
    task automatic test_random_phase(input int m, input int p, input int count);
        int          kind;
        logic [3:0]  i1;
        logic [3:0]  i2;
        logic [3:0]  i3;
        logic [3:0]  i4;
        write_reg(fmrb_pkg::CFG_NUM_ORBITALS, 5'(m));
        write_reg(fmrb_pkg::CFG_NUM_PARTICLES, 5'(p));
        for (int n = 0; n < count; n++)
        begin
            kind = $urandom_range(0, 9);
            i1 = 4'($urandom_range(0, 15));
            i2 = 4'($urandom_range(0, 15));
            i3 = 4'($urandom_range(0, 15));
            i4 = 4'($urandom_range(0, 15));
            if (kind < 2)
                send_item(fmrb_pkg::OP_ENERGY, 4'($urandom_range(0, m/2 - 1)), i2, i3, i4,
                          rand_value());
            else if (kind < 4)
                send_item(fmrb_pkg::OP_COULOMB, 4'($urandom_range(0, m/2 - 1)),
                          4'($urandom_range(0, m/2 - 1)), 4'($urandom_range(0, m/2 - 1)),
                          4'($urandom_range(0, m/2 - 1)), rand_value());
            else if (kind < 6)
                send_item(fmrb_pkg::OP_COEF, 4'($urandom_range(0, p - 1)),
                          4'($urandom_range(0, m - 1)), i3, i4, rand_value());
            else if (kind == 6)
                send_item(fmrb_pkg::op_t'($urandom_range(0, 2)), i1, i2, i3, i4, $urandom());
            else if (kind == 7)
                send_item(fmrb_pkg::OP_COMPUTE, i1, i2, i3, i4, $urandom());
            else
                send_item(fmrb_pkg::OP_COMPUTE, 4'($urandom_range(0, m - 1)), i2, i3, i4,
                          $urandom());
        end
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial
    begin
        int waited;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = fmrb_pkg::OP_ENERGY;
        cfg_valid     = 1'b0;
        cfg_index     = fmrb_pkg::CFG_NUM_ORBITALS;
        cfg_data      = '0;
        quiet         = 1'b0;
        sink_hold     = 0;
        error_count   = 0;
        orbitals_reg  = 5'd16;
        particles_reg = 4'd2;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        test_fill_stores();
        test_extremes();
        test_backpressure();
        test_random_phase(4, 2, 8);
        test_random_phase(2, 3, 8);
        test_random_phase(4, 1, 8);
        quiet = 1'b1;
        test_random_phase(4, 3, 8);

        drop_valid();
        waited = 0;
        while (pending_elems.size() != 0 && waited < 400000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (100) @(negedge clk);
        if (error_count == 0 && pending_elems.size() == 0)
            $display("[fock_matrix_row_build] OK");
        else
            $display("[fock_matrix_row_build] ERROR");
        $finish;
    end

    initial
    begin
        #6000000;
        $display("[fock_matrix_row_build] ERROR");
        $finish;
    end

endmodule
